// ----- src/rast_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range add / assign / sum tree - shared package
// Command and result payloads, tree node record, sequencer states and the
// tag-apply helper used on every tag push and update of a node.
// ----------------------------------------------------------------------------
package rast_pkg;

  localparam int VALUE_W              = 32;
  localparam int SHIFT_W              = 5;
  localparam int DEFAULT_MAX_ELEMENTS = 1024;
  localparam int SIZE_RESET           = 1024;
  localparam int CFG_DATA_W           = 32;
  localparam int CFG_ADDR_W           = 2;
  localparam int CFG_SIZE_BITS        = 11;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_IN_USE = 2'd0;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [9:0]                left;
    logic [9:0]                right;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] range_sum;
    logic                      range_error;
  } res_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sum;
    logic [VALUE_W-1:0] amt;
    logic               valid;
    logic               is_set;
  } node_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_PUSH_L,
    S_PUSH_R,
    S_DOWN,
    S_UP,
    S_FIX_L,
    S_FIX_R,
    S_FIX_P,
    S_FIX_W,
    S_DONE
  } state_t;

  // Node length is a power of two, so length times value is a shift.
  function automatic node_t apply_tag(node_t nd, logic [VALUE_W-1:0] v,
                                      logic is_set, logic [SHIFT_W-1:0] k);
    node_t              o;
    logic [VALUE_W-1:0] total;
    total = v << k;
    o     = nd;
    if (is_set) begin
      o.sum    = total;
      o.amt    = v;
      o.is_set = 1'b1;
    end else begin
      o.sum = nd.sum + total;
      if (nd.valid) begin
        o.amt = nd.amt + v;
      end else begin
        o.amt    = v;
        o.is_set = 1'b0;
      end
    end
    o.valid = 1'b1;
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- src/range_add_assign_sum_tree_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range add / assign / sum tree - top level
// Keeps MAX_ELEMENTS values as a lazy sum tree; adds to, sets or sums an
// inclusive index range per command.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result
// appears for a single cycle with done high and cannot be held off. A rejected
// command (bad range or unused code) returns its result in the next cycle.
// Other commands walk the two boundary paths of the tree through the node
// store's one read port and one write port: on the way down each partly
// covered node is read, evaluated and left for a child, with a pending tag
// first handed to both children; a fully covered node is read and evaluated;
// each step back up passes the up state, and on updates each level then reads
// both children and writes back the parent sum. A command over the whole array
// is settled at the root alone. After reset all 2*2^ceil(log2(MAX_ELEMENTS))
// nodes of the store (2048 by default) are swept clear with busy high; register
// writes are taken throughout.
module range_add_assign_sum_tree_core #(
  parameter int MAX_ELEMENTS = rast_pkg::DEFAULT_MAX_ELEMENTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  rast_pkg::req_t                         request,
  output logic                                   busy,
  output logic                                   done,
  output rast_pkg::res_t                         result,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rast_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [rast_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rast_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import rast_pkg::*;

  localparam int SIZE_W     = $clog2(MAX_ELEMENTS + 1);
  localparam int SIZE_INIT  = (SIZE_RESET > MAX_ELEMENTS) ? MAX_ELEMENTS : SIZE_RESET;

  logic [SIZE_W-1:0]        size;
  logic [CFG_SIZE_BITS-1:0] wr_val;

  assign wr_val = pwdata[CFG_SIZE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= SIZE_W'(SIZE_INIT);
    end else if (psel && penable && pwrite) begin
      // saturate oversize writes to MAX_ELEMENTS
      if (32'(wr_val) > MAX_ELEMENTS) begin
        size <= SIZE_W'(MAX_ELEMENTS);
      end else begin
        size <= SIZE_W'(wr_val);
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_SIZE_IN_USE) ? CFG_DATA_W'(size) : '0;

  rast_seq #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .SIZE_W       (SIZE_W)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .size    (size),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  a_take_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted command neither finished nor in progress");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.range_error) |-> (result.range_sum == '0))
    else $error("rejected command returned a non-zero sum");

  a_clear_busy: assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("store clear sweep not running after reset");

endmodule
`default_nettype wire

// ----- src/rast_node_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tree node store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rast_node_ram #(
  parameter int ADDR_W = 11
) (
  input  wire logic                  clk,
  input  wire logic [ADDR_W-1:0]     rd_addr,
  output rast_pkg::node_t            rd_data,
  input  wire logic                  wr_en,
  input  wire logic [ADDR_W-1:0]     wr_addr,
  input  rast_pkg::node_t            wr_data
);
  import rast_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  node_t mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- src/rast_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tree walk sequencer
// Walks the sum tree depth first without a stack, pushing pending tags,
// applying updates, accumulating query sums and rebuilding parent sums.
// ----------------------------------------------------------------------------
module rast_seq #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int SIZE_W       = 11
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  rast_pkg::req_t         request,
  input  wire logic [SIZE_W-1:0] size,
  output logic                   busy,
  output logic                   done,
  output rast_pkg::res_t         result
);
  import rast_pkg::*;

  localparam int LOG_LEAVES = $clog2(MAX_ELEMENTS);
  localparam int IDX_W      = LOG_LEAVES;
  localparam int ADDR_W     = LOG_LEAVES + 1;
  localparam int DEP_W      = $clog2(LOG_LEAVES + 1);

  state_t              state, state_next;
  logic [ADDR_W-1:0]   n, n_next;
  logic [IDX_W-1:0]    lo, lo_next;
  logic [DEP_W-1:0]    dep, dep_next;
  logic [IDX_W-1:0]    l, l_next;
  logic [IDX_W-1:0]    r, r_next;
  logic [VALUE_W-1:0]  v, v_next;
  logic                is_set, is_set_next;
  logic                is_query, is_query_next;
  logic [VALUE_W-1:0]  acc, acc_next;
  logic [VALUE_W-1:0]  lsum, lsum_next;
  node_t               pend, pend_next;
  logic [ADDR_W-1:0]   clr, clr_next;
  res_t                res, res_next;
  logic                res_valid, res_valid_next;

  logic [ADDR_W-1:0]   rd_addr;
  node_t               rd_data;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  node_t               wr_data;

  logic [SHIFT_W-1:0]  k;
  logic [IDX_W:0]      span;
  logic [IDX_W-1:0]    span_m1;
  logic [IDX_W-1:0]    hi;
  logic [IDX_W-1:0]    mid;
  logic                covered;
  logic [ADDR_W-1:0]   lchild;
  logic [ADDR_W-1:0]   rchild;
  logic                bad;

  rast_node_ram #(
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign k       = SHIFT_W'(LOG_LEAVES) - SHIFT_W'(dep);
  assign span    = (IDX_W + 1)'(1) << k;
  assign span_m1 = IDX_W'(span - 1'b1);
  assign hi      = lo + span_m1;
  assign mid     = lo + (span_m1 >> 1);
  assign covered = (l <= lo) && (hi <= r);
  assign lchild  = {n[ADDR_W-2:0], 1'b0};
  assign rchild  = {n[ADDR_W-2:0], 1'b1};
  assign bad     = (request.cmd == CMD_UNUSED) || (request.left > request.right) ||
                   (32'(request.right) >= 32'(size));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    n        <= n_next;
    lo       <= lo_next;
    dep      <= dep_next;
    l        <= l_next;
    r        <= r_next;
    v        <= v_next;
    is_set   <= is_set_next;
    is_query <= is_query_next;
    acc      <= acc_next;
    lsum     <= lsum_next;
    pend     <= pend_next;
    res      <= res_next;
  end

  always_comb begin
    state_next     = state;
    n_next         = n;
    lo_next        = lo;
    dep_next       = dep;
    l_next         = l;
    r_next         = r;
    v_next         = v;
    is_set_next    = is_set;
    is_query_next  = is_query;
    acc_next       = acc;
    lsum_next      = lsum;
    pend_next      = pend;
    clr_next       = clr;
    res_next       = res;
    res_valid_next = 1'b0;
    rd_addr        = n;
    wr_en          = 1'b0;
    wr_addr        = n;
    wr_data        = rd_data;
    case (state)
      S_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = clr;
        wr_data  = '0;
        clr_next = clr + 1'b1;
        if (clr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (bad) begin
            res_valid_next       = 1'b1;
            res_next.range_sum   = '0;
            res_next.range_error = 1'b1;
          end else begin
            l_next        = IDX_W'(request.left);
            r_next        = IDX_W'(request.right);
            v_next        = request.value;
            is_set_next   = (request.cmd == CMD_SET);
            is_query_next = (request.cmd == CMD_QUERY);
            n_next        = ADDR_W'(1);
            lo_next       = '0;
            dep_next      = '0;
            acc_next      = '0;
            state_next    = S_READ;
          end
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (covered) begin
          if (is_query) begin
            acc_next = acc + rd_data.sum;
          end else begin
            wr_en   = 1'b1;
            wr_data = apply_tag(rd_data, v, is_set, k);
          end
          state_next = S_UP;
        end else if (rd_data.valid) begin
          // hand the tag down before visiting part of this node
          wr_en         = 1'b1;
          wr_data.valid = 1'b0;
          pend_next     = rd_data;
          rd_addr       = lchild;
          state_next    = S_PUSH_L;
        end else begin
          state_next = S_DOWN;
        end
      end
      S_PUSH_L: begin
        wr_en      = 1'b1;
        wr_addr    = lchild;
        wr_data    = apply_tag(rd_data, pend.amt, pend.is_set, k - 1'b1);
        rd_addr    = rchild;
        state_next = S_PUSH_R;
      end
      S_PUSH_R: begin
        wr_en      = 1'b1;
        wr_addr    = rchild;
        wr_data    = apply_tag(rd_data, pend.amt, pend.is_set, k - 1'b1);
        state_next = S_DOWN;
      end
      S_DOWN: begin
        if (l <= mid) begin
          n_next = lchild;
        end else begin
          n_next  = rchild;
          lo_next = mid + 1'b1;
        end
        dep_next   = dep + 1'b1;
        state_next = S_READ;
      end
      S_UP: begin
        if (n == ADDR_W'(1)) begin
          state_next = S_DONE;
        end else if (!n[0] && (hi < r)) begin
          // advance to the right sibling
          n_next     = n + 1'b1;
          lo_next    = hi + 1'b1;
          state_next = S_READ;
        end else begin
          n_next     = n >> 1;
          lo_next    = n[0] ? (lo - span_m1 - 1'b1) : lo;
          dep_next   = dep - 1'b1;
          state_next = is_query ? S_UP : S_FIX_L;
        end
      end
      S_FIX_L: begin
        rd_addr    = lchild;
        state_next = S_FIX_R;
      end
      S_FIX_R: begin
        lsum_next  = rd_data.sum;
        rd_addr    = rchild;
        state_next = S_FIX_P;
      end
      S_FIX_P: begin
        lsum_next  = lsum + rd_data.sum;
        state_next = S_FIX_W;
      end
      S_FIX_W: begin
        wr_en       = 1'b1;
        wr_data.sum = lsum;
        state_next  = S_UP;
      end
      S_DONE: begin
        res_valid_next       = 1'b1;
        res_next.range_sum   = is_query ? acc : '0;
        res_next.range_error = 1'b0;
        state_next           = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy   = (state != S_IDLE);
  assign done   = res_valid;
  assign result = res;

endmodule
`default_nettype wire
